// ----- rtl/core/crsd_pkg.sv -----
// Shared types, constants and functions for the RRIP/SHiP/DIP replacement block.
package crsd_pkg;

    localparam int NumSets    = 2048;
    localparam int NumWays    = 16;
    localparam int LeaderSets = 32;
    localparam int SetW       = $clog2(NumSets);
    localparam int WayW       = $clog2(NumWays);
    localparam int RowW       = 2 * NumWays;
    localparam int SigRowW    = 5 * NumWays;
    localparam int LeadStep   = NumSets / LeaderSets;
    localparam int LeadW      = $clog2(LeadStep);
    localparam int SelMax     = 1023;
    localparam int QDepth     = 2;

    localparam logic [1:0]  RrpvMax   = 2'd3;
    localparam logic [2:0]  ConfMax   = 3'd7;
    localparam logic [2:0]  StrmThrRst = 3'd5;
    localparam logic [1:0]  ReuseThrRst = 2'd2;
    localparam logic [9:0]  DuelThrRst = 10'd512;
    localparam logic [7:0]  BimPerRst = 8'd32;
    localparam logic [9:0]  SelRst    = 10'd512;

    typedef enum logic [1:0] {
        CFG_STREAM = 2'd0,
        CFG_REUSE  = 2'd1,
        CFG_DUEL   = 2'd2,
        CFG_BIMOD  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_WRITE
    } t_state;

    // One classified item passed from the front to the back.
    typedef struct packed {
        logic             mode;
        logic [SetW-1:0]  set_idx;
        logic [WayW-1:0]  way_idx;
        logic             way_ok;
        logic [15:0]      valid_mask;
        logic [4:0]       sig;
        logic [63:0]      paddr;
        logic             hit;
        logic             lip_lead;
        logic             bip_lead;
    } t_item;

    typedef struct packed {
        logic [2:0] stream_thr;
        logic [1:0] reuse_thr;
        logic [9:0] duel_thr;
        logic [7:0] bim_per;
    } t_cfg;

    function automatic logic [4:0] make_sig(input logic [63:0] pc);
        logic [63:0] x;
        x = pc ^ (pc >> 7) ^ (pc >> 13);
        return x[4:0];
    endfunction

endpackage

// ----- rtl/core/crsd_front.sv -----
// Front end: takes items, classifies them and queues them for the back end.
module crsd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  logic            i_mode,
    input  logic [10:0]     i_set_index,
    input  logic [3:0]      i_way_index,
    input  logic [15:0]     i_valid_mask,
    input  logic [63:0]     i_pc,
    input  logic [63:0]     i_paddr,
    input  logic            i_hit,
    output logic            o_q_valid,
    output crsd_pkg::t_item o_q_item,
    input  logic            i_q_take
);

    crsd_pkg::t_item r_q [crsd_pkg::QDepth];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    crsd_pkg::t_item w_item;
    logic [crsd_pkg::SetW-1:0] w_set;
    logic            w_push, w_pop;

    // Classification: set index, way range, signature, leader role
    always_comb begin
        w_set            = i_set_index[crsd_pkg::SetW-1:0];
        w_item.mode      = i_mode;
        w_item.set_idx   = w_set;
        w_item.way_idx   = i_way_index[crsd_pkg::WayW-1:0];
        w_item.way_ok    = ({1'b0, i_way_index} < 5'(crsd_pkg::NumWays));
        w_item.valid_mask = i_valid_mask;
        w_item.sig       = crsd_pkg::make_sig(i_pc);
        w_item.paddr     = i_paddr;
        w_item.hit       = i_hit;
        w_item.lip_lead  = (w_set[crsd_pkg::LeadW-1:0] == '0);
        w_item.bip_lead  = (w_set[crsd_pkg::LeadW-1:0] == crsd_pkg::LeadW'(1));
    end

    assign o_full    = (r_cnt == 2'(crsd_pkg::QDepth));
    assign w_push    = i_push && !o_full;
    assign o_q_valid = (r_cnt != 2'd0);
    assign w_pop     = i_q_take && o_q_valid;
    assign o_q_item  = r_q[r_rp];

    // Two-entry queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_item;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(crsd_pkg::QDepth)) else $error("queue overfilled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && !w_push |=> r_cnt == $past(r_cnt) - 2'd1) else $error("pop count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !w_pop) else $error("pop from empty");

endmodule

// ----- rtl/core/crsd_back.sv -----
// Back end: set metadata memories, aging, training and result register.
module crsd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  crsd_pkg::t_item i_q_item,
    output logic            o_q_take,
    input  crsd_pkg::t_cfg  i_cfg,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [3:0]      o_victim_way,
    output logic            o_victim_was_invalid
);

    // Per-set rows: RRPVs, signatures, stride detector
    logic [crsd_pkg::RowW-1:0]    m_rrpv  [crsd_pkg::NumSets];
    logic [crsd_pkg::SigRowW-1:0] m_sig   [crsd_pkg::NumSets];
    logic [63:0]                  m_addr  [crsd_pkg::NumSets];
    logic [63:0]                  m_strd  [crsd_pkg::NumSets];
    logic [3:0]                   m_conf  [crsd_pkg::NumSets];

    logic [1:0]  r_reuse [32];
    logic [9:0]  r_psel;
    logic [7:0]  r_bim;

    crsd_pkg::t_state r_state, n_state;
    logic [crsd_pkg::SetW-1:0] r_clr;
    crsd_pkg::t_item r_it;

    logic [crsd_pkg::RowW-1:0]    r_rrpv_rd, w_rrpv_new;
    logic [crsd_pkg::SigRowW-1:0] r_sig_rd, w_sig_new;
    logic [63:0] r_addr_rd, r_strd_rd, r_stride;
    logic [3:0]  r_conf_rd, r_conf_new;
    logic [1:0]  r_top;
    logic        r_seq;

    logic        r_out_v;
    logic [3:0]  r_out_way;
    logic        r_out_inv;

    logic        w_take, w_rd, w_wr, w_clr_wr, w_exec;
    logic        w_strm, w_match;
    logic [2:0]  w_conf_nx;
    logic [1:0]  w_top;
    logic [crsd_pkg::WayW-1:0] w_inv_way, w_three_way;
    logic        w_inv_found;
    logic [crsd_pkg::RowW-1:0] w_aged;
    logic [4:0]  w_bsig;
    logic        w_use_bip;
    logic [1:0]  w_ins;

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            crsd_pkg::ST_CLEAR: if (r_clr == '1) n_state = crsd_pkg::ST_IDLE;
            crsd_pkg::ST_IDLE:  if (i_q_valid && !r_out_v) n_state = crsd_pkg::ST_READ;
            crsd_pkg::ST_READ:  n_state = crsd_pkg::ST_EXEC;
            crsd_pkg::ST_EXEC:  n_state = crsd_pkg::ST_WRITE;
            crsd_pkg::ST_WRITE: n_state = crsd_pkg::ST_IDLE;
            default:            n_state = crsd_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        w_take = 1'b0; w_rd = 1'b0; w_exec = 1'b0; w_wr = 1'b0; w_clr_wr = 1'b0;
        unique case (r_state)
            crsd_pkg::ST_CLEAR: w_clr_wr = 1'b1;
            crsd_pkg::ST_IDLE:  w_take = i_q_valid && !r_out_v;
            crsd_pkg::ST_READ:  w_rd = 1'b1;
            crsd_pkg::ST_EXEC:  w_exec = 1'b1;
            crsd_pkg::ST_WRITE: w_wr = 1'b1;
            default: ;
        endcase
    end
    assign o_q_take = w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crsd_pkg::ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == crsd_pkg::ST_CLEAR) r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_it <= i_q_item;
    end

    // Memory ports: one read a cycle, one write a cycle (clear pass or write-back)
    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            r_rrpv_rd <= m_rrpv[r_it.set_idx];
            r_sig_rd  <= m_sig[r_it.set_idx];
            r_addr_rd <= m_addr[r_it.set_idx];
            r_strd_rd <= m_strd[r_it.set_idx];
            r_conf_rd <= m_conf[r_it.set_idx];
        end
        if (w_clr_wr) begin
            m_rrpv[r_clr] <= '1;
            m_sig[r_clr]  <= '0;
            m_addr[r_clr] <= '0;
            m_strd[r_clr] <= '0;
            m_conf[r_clr] <= '0;
        end else if (w_wr) begin
            m_rrpv[r_it.set_idx] <= w_rrpv_new;
            if (r_it.mode) begin
                m_sig[r_it.set_idx]  <= w_sig_new;
                m_addr[r_it.set_idx] <= r_it.paddr;
                m_strd[r_it.set_idx] <= r_stride;
                m_conf[r_it.set_idx] <= r_conf_new;
            end
        end
    end

    // Streaming bit sits in m_conf[3]; stride compare and confidence step
    assign w_strm  = r_conf_rd[3];
    assign w_match = (r_addr_rd != 64'd0) && (r_it.paddr - r_addr_rd == r_strd_rd);
    always_comb begin
        if (w_match) w_conf_nx = (r_conf_rd[2:0] == crsd_pkg::ConfMax) ?
                                 r_conf_rd[2:0] : r_conf_rd[2:0] + 3'd1;
        else         w_conf_nx = (r_conf_rd[2:0] == 3'd0) ? 3'd0 : r_conf_rd[2:0] - 3'd1;
    end

    // Top RRPV, first invalid way, aged row, first way at 3
    always_comb begin
        w_top = 2'd0;
        w_inv_found = 1'b0;
        w_inv_way = '0;
        for (int w = 0; w < crsd_pkg::NumWays; w++) begin
            if (r_rrpv_rd[2*w +: 2] > w_top) w_top = r_rrpv_rd[2*w +: 2];
            if (w < 16 && !w_inv_found && !r_it.valid_mask[w]) begin
                w_inv_found = 1'b1;
                w_inv_way = crsd_pkg::WayW'(w);
            end
        end
    end

    always_comb begin
        w_three_way = '0;
        for (int w = crsd_pkg::NumWays - 1; w >= 0; w--) begin
            w_aged[2*w +: 2] = r_rrpv_rd[2*w +: 2] + (crsd_pkg::RrpvMax - r_top);
            if (w_aged[2*w +: 2] == crsd_pkg::RrpvMax) w_three_way = crsd_pkg::WayW'(w);
        end
    end

    assign w_bsig = r_sig_rd[5*r_it.way_idx +: 5];
    always_comb begin
        if (r_it.lip_lead)      w_use_bip = 1'b0;
        else if (r_it.bip_lead) w_use_bip = 1'b1;
        else                    w_use_bip = (r_psel >= i_cfg.duel_thr);
        if (r_seq)                                       w_ins = crsd_pkg::RrpvMax;
        else if (r_reuse[r_it.sig] >= i_cfg.reuse_thr)   w_ins = 2'd0;
        else if (w_use_bip)  w_ins = (r_bim == 8'd0) ? 2'd0 : crsd_pkg::RrpvMax;
        else                                             w_ins = crsd_pkg::RrpvMax;
    end

    // Exec stage 1 (after read): stride, confidence, top
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_stride   <= r_it.paddr - r_addr_rd;
            r_conf_new <= {(w_conf_nx >= i_cfg.stream_thr), w_conf_nx};
            r_seq      <= (w_conf_nx >= i_cfg.stream_thr);
            r_top      <= w_top;
        end
    end

    // Write stage: build new rows, train tables, produce result
    always_comb begin
        w_rrpv_new = r_rrpv_rd;
        w_sig_new  = r_sig_rd;
        if (!r_it.mode) begin
            if (!(w_strm && w_inv_found)) w_rrpv_new = w_aged;
        end else if (r_it.way_ok) begin
            w_rrpv_new[2*r_it.way_idx +: 2] = r_it.hit ? 2'd0 : w_ins;
            if (!r_it.hit) w_sig_new[5*r_it.way_idx +: 5] = r_it.sig;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 32; i++) r_reuse[i] <= 2'd1;
            r_psel  <= crsd_pkg::SelRst;
            r_bim   <= 8'd0;
            r_out_v <= 1'b0;
        end else begin
            if (i_pop && r_out_v) r_out_v <= 1'b0;
            if (w_wr) begin
                if (!r_it.mode) begin
                    r_out_v <= 1'b1;
                end else if (r_it.hit) begin
                    if (r_it.way_ok && r_reuse[w_bsig] != 2'd3)
                        r_reuse[w_bsig] <= r_reuse[w_bsig] + 2'd1;
                    if (r_it.lip_lead && r_it.bip_lead) r_psel <= r_psel;
                    else if (r_it.lip_lead && r_psel != 10'(crsd_pkg::SelMax))
                        r_psel <= r_psel + 10'd1;
                    else if (r_it.bip_lead && r_psel != 10'd0) r_psel <= r_psel - 10'd1;
                end else begin
                    if (!r_seq && r_reuse[r_it.sig] < i_cfg.reuse_thr && w_use_bip)
                        r_bim <= ({1'b0, r_bim} + 9'd1 >= {1'b0, i_cfg.bim_per}) ?
                                 8'd0 : r_bim + 8'd1;
                    if (r_reuse[r_it.sig] != 2'd0)
                        r_reuse[r_it.sig] <= r_reuse[r_it.sig] - 2'd1;
                    if (r_it.lip_lead && r_it.bip_lead) r_psel <= r_psel;
                    else if (r_it.lip_lead && r_psel != 10'd0) r_psel <= r_psel - 10'd1;
                    else if (r_it.bip_lead && r_psel != 10'(crsd_pkg::SelMax))
                        r_psel <= r_psel + 10'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr && !r_it.mode) begin
            r_out_way <= 4'((w_strm && w_inv_found) ? w_inv_way : w_three_way);
            r_out_inv <= w_strm && w_inv_found;
        end
    end

    assign o_empty              = !r_out_v;
    assign o_victim_way         = r_out_way;
    assign o_victim_was_invalid = r_out_inv;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> !r_out_v) else $error("took item with result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr && !r_it.mode |=> r_out_v) else $error("victim result lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !i_pop |=> r_out_v) else $error("result dropped");

endmodule

// ----- rtl/core/cache_replacement_ship_dip_stream.sv -----
// Top level: config registers, front classifier and back executor.
//  channel | direction | handshake      | payload
//  input   | in        | push / full    | mode set_index way_index valid_mask pc paddr hit
//  result  | out       | pop / empty    | victim_way victim_was_invalid
//  config  | in        | valid / ready  | cfg index, cfg data
// In the back end an item passes through four steps: take, read set row, compute, write back.
// The set row memory has one read and one write port; a new item is taken only after the last is written back.
// After reset a clearing pass writes every set row; no item is taken then.
// A pending victim result holds the back end until it is popped; the front queue holds two.
// Configuration writes are accepted in every cycle.
module cache_replacement_ship_dip_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_mode,
    input  logic [10:0] i_set_index,
    input  logic [3:0]  i_way_index,
    input  logic [15:0] i_valid_mask,
    input  logic [63:0] i_pc,
    input  logic [63:0] i_paddr,
    input  logic        i_hit,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_victim_way,
    output logic        o_victim_was_invalid,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    crsd_pkg::t_cfg  r_cfg;
    crsd_pkg::t_item w_item;
    logic            w_q_valid, w_q_take;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stream_thr <= crsd_pkg::StrmThrRst;
            r_cfg.reuse_thr  <= crsd_pkg::ReuseThrRst;
            r_cfg.duel_thr   <= crsd_pkg::DuelThrRst;
            r_cfg.bim_per    <= crsd_pkg::BimPerRst;
        end else if (i_cfg_valid) begin
            unique case (crsd_pkg::t_cfg_idx'(i_cfg_index))
                crsd_pkg::CFG_STREAM: r_cfg.stream_thr <= i_cfg_data[2:0];
                crsd_pkg::CFG_REUSE:  r_cfg.reuse_thr  <= i_cfg_data[1:0];
                crsd_pkg::CFG_DUEL:   r_cfg.duel_thr   <= i_cfg_data;
                crsd_pkg::CFG_BIMOD:  r_cfg.bim_per    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    crsd_front u_front (
        .i_clk, .i_rst_n,
        .i_push (push), .o_full (full),
        .i_mode, .i_set_index, .i_way_index, .i_valid_mask, .i_pc, .i_paddr, .i_hit,
        .o_q_valid (w_q_valid), .o_q_item (w_item), .i_q_take (w_q_take)
    );

    crsd_back u_back (
        .i_clk, .i_rst_n,
        .i_q_valid (w_q_valid), .i_q_item (w_item), .o_q_take (w_q_take),
        .i_cfg (r_cfg),
        .o_empty (empty), .i_pop (pop),
        .o_victim_way, .o_victim_was_invalid
    );

endmodule

// ----- tb/sv/tb_cache_replacement_ship_dip_stream.sv -----
// Self-checking testbench for the RRIP/SHiP/DIP cache replacement block.
module tb_cache_replacement_ship_dip_stream;

    typedef struct {
        bit          mode;
        bit [10:0]   set_index;
        bit [3:0]    way_index;
        bit [15:0]   valid_mask;
        bit [63:0]   pc;
        bit [63:0]   paddr;
        bit          hit;
    } t_access;

    typedef struct {
        bit [3:0] way;
        bit       was_invalid;
    } t_victim;

    // Replacement-state mirror: predicts each victim choice and checks it.
    class t_victim_tracker;
        bit [1:0]  rrpv [crsd_pkg::NumSets*crsd_pkg::NumWays];
        bit [4:0]  blk_sig [crsd_pkg::NumSets*crsd_pkg::NumWays];
        bit [1:0]  reuse [32];
        bit [63:0] prev_addr [crsd_pkg::NumSets];
        bit [63:0] last_stride [crsd_pkg::NumSets];
        bit [2:0]  conf [crsd_pkg::NumSets];
        bit        streaming [crsd_pkg::NumSets];
        int        psel;
        int        bip_count;
        int        stream_thr;
        int        reuse_thr;
        int        duel_thr;
        int        bip_period;
        t_victim   pending_victims [$];
        int        errors;
        int        victims_checked;
        int        stream_hits;

        function new();
            foreach (rrpv[i]) rrpv[i] = crsd_pkg::RrpvMax;
            foreach (blk_sig[i]) blk_sig[i] = '0;
            foreach (reuse[i]) reuse[i] = 2'd1;
            foreach (prev_addr[i]) begin
                prev_addr[i] = '0;
                last_stride[i] = '0;
                conf[i] = '0;
                streaming[i] = 1'b0;
            end
            psel = crsd_pkg::SelRst;
            bip_count = 0;
            stream_thr = crsd_pkg::StrmThrRst;
            reuse_thr = crsd_pkg::ReuseThrRst;
            duel_thr = crsd_pkg::DuelThrRst;
            bip_period = crsd_pkg::BimPerRst;
            errors = 0;
            victims_checked = 0;
            stream_hits = 0;
        endfunction

        function void set_reg(crsd_pkg::t_cfg_idx idx, bit [9:0] data);
            case (idx)
                crsd_pkg::CFG_STREAM: stream_thr = data[2:0];
                crsd_pkg::CFG_REUSE:  reuse_thr = data[1:0];
                crsd_pkg::CFG_DUEL:   duel_thr = data;
                crsd_pkg::CFG_BIMOD:  bip_period = data[7:0];
            endcase
        endfunction

        // Accepted access: update the mirror, queue a victim if one is due
        function void predict_access(t_access a);
            int        s;
            int        base;
            int        slot;
            int        top;
            int        w;
            bit [63:0] stride;
            bit [63:0] x;
            bit [4:0]  sig;
            bit [4:0]  bs;
            bit        lip_lead;
            bit        bip_lead;
            bit        use_bip;
            bit [1:0]  ins;
            t_victim   v;
            s = a.set_index;
            base = s * crsd_pkg::NumWays;
            if (!a.mode) begin
                // streaming sets take the first invalid way
                if (streaming[s]) begin
                    for (w = 0; w < crsd_pkg::NumWays; w++) begin
                        if (!a.valid_mask[w]) begin
                            v.way = 4'(w);
                            v.was_invalid = 1'b1;
                            pending_victims.push_back(v);
                            stream_hits++;
                            return;
                        end
                    end
                end
                // age until the oldest block reaches distant re-reference
                top = 0;
                for (w = 0; w < crsd_pkg::NumWays; w++)
                    if (rrpv[base+w] > top) top = rrpv[base+w];
                if (top < 3)
                    for (w = 0; w < crsd_pkg::NumWays; w++)
                        rrpv[base+w] = 2'(rrpv[base+w] + (3 - top));
                for (w = 0; w < crsd_pkg::NumWays; w++)
                    if (rrpv[base+w] == crsd_pkg::RrpvMax) break;
                if (w >= crsd_pkg::NumWays) w = 0;
                v.way = 4'(w);
                v.was_invalid = 1'b0;
                pending_victims.push_back(v);
                return;
            end
            // stride detector
            stride = a.paddr - prev_addr[s];
            if (prev_addr[s] != 0 && stride == last_stride[s]) begin
                if (conf[s] < crsd_pkg::ConfMax) conf[s]++;
            end else if (conf[s] > 0) begin
                conf[s]--;
            end
            prev_addr[s] = a.paddr;
            last_stride[s] = stride;
            streaming[s] = (conf[s] >= stream_thr);
            x = a.pc ^ (a.pc >> 7) ^ (a.pc >> 13);
            sig = x[4:0];
            slot = base + a.way_index;
            lip_lead = (s % crsd_pkg::LeadStep) == 0;
            bip_lead = (s % crsd_pkg::LeadStep) == 1;
            if (lip_lead) use_bip = 1'b0;
            else if (bip_lead) use_bip = 1'b1;
            else use_bip = psel >= duel_thr;
            if (a.hit) begin
                bs = blk_sig[slot];
                rrpv[slot] = 2'd0;
                if (reuse[bs] < 3) reuse[bs]++;
                if (lip_lead && psel < crsd_pkg::SelMax) psel++;
                if (bip_lead && psel > 0) psel--;
                return;
            end
            // fill: choose insertion position
            if (streaming[s]) begin
                ins = crsd_pkg::RrpvMax;
            end else if (reuse[sig] >= reuse_thr) begin
                ins = 2'd0;
            end else if (use_bip) begin
                ins = (bip_count == 0) ? 2'd0 : crsd_pkg::RrpvMax;
                bip_count = (bip_count + 1 >= bip_period) ? 0 : bip_count + 1;
            end else begin
                ins = crsd_pkg::RrpvMax;
            end
            blk_sig[slot] = sig;
            rrpv[slot] = ins;
            if (reuse[sig] > 0) reuse[sig]--;
            if (lip_lead && psel > 0) psel--;
            if (bip_lead && psel < crsd_pkg::SelMax) psel++;
        endfunction

        function void check_victim(bit [3:0] way, bit was_invalid);
            t_victim v;
            if (pending_victims.size() == 0) begin
                $error("victim result with none expected: way %0d invalid %0d",
                       way, was_invalid);
                errors++;
                return;
            end
            v = pending_victims.pop_front();
            victims_checked++;
            if (way !== v.way) begin
                $error("victim_way: expected %0d, got %0d", v.way, way);
                errors++;
            end
            if (was_invalid !== v.was_invalid) begin
                $error("victim_was_invalid: expected %0d, got %0d", v.was_invalid, was_invalid);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_mode = 1'b0;
    logic [10:0] i_set_index = '0;
    logic [3:0]  i_way_index = '0;
    logic [15:0] i_valid_mask = '0;
    logic [63:0] i_pc = '0;
    logic [63:0] i_paddr = '0;
    logic        i_hit = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [3:0]  o_victim_way;
    logic        o_victim_was_invalid;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [9:0]  i_cfg_data = '0;

    t_victim_tracker tracker = new();
    int  items_sent = 0;
    bit  hold_req = 1'b0;
    bit  burst = 1'b0;

    cache_replacement_ship_dip_stream dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_mode(i_mode), .i_set_index(i_set_index), .i_way_index(i_way_index),
        .i_valid_mask(i_valid_mask), .i_pc(i_pc), .i_paddr(i_paddr), .i_hit(i_hit),
        .empty(empty), .pop(pop),
        .o_victim_way(o_victim_way), .o_victim_was_invalid(o_victim_was_invalid),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Run limit: covers the clearing pass, all stalls and every gap many times over
    initial begin
        #40000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Mostly short gaps, a few long ones, none during a burst
    function automatic int pick_gap();
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 19);
        if (r < 13) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one item and wait for it to be taken
    task automatic send(t_access a);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_mode <= a.mode;
        i_set_index <= a.set_index;
        i_way_index <= a.way_index;
        i_valid_mask <= a.valid_mask;
        i_pc <= a.pc;
        i_paddr <= a.paddr;
        i_hit <= a.hit;
        do @(posedge i_clk); while (full);
        tracker.predict_access(a);
        items_sent++;
    endtask

    task automatic send_fields(bit mode, bit [10:0] set_index, bit [3:0] way_index,
                               bit [15:0] mask, bit [63:0] pc, bit [63:0] paddr, bit hit);
        t_access a;
        a.mode = mode;
        a.set_index = set_index;
        a.way_index = way_index;
        a.valid_mask = mask;
        a.pc = pc;
        a.paddr = paddr;
        a.hit = hit;
        send(a);
    endtask

    // Idle the input and wait until every victim has come back
    task automatic drain();
        push <= 1'b0;
        while (tracker.pending_victims.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(crsd_pkg::t_cfg_idx idx, bit [9:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(bit [2:0] st, bit [1:0] rt, bit [9:0] dt, bit [7:0] bp);
        drain();
        write_reg(crsd_pkg::CFG_STREAM, 10'(st));
        write_reg(crsd_pkg::CFG_REUSE, 10'(rt));
        write_reg(crsd_pkg::CFG_DUEL, dt);
        write_reg(crsd_pkg::CFG_BIMOD, 10'(bp));
    endtask

    function automatic bit [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random traffic: mostly strided runs on a few sets, the rest plain noise
    task automatic random_phase(int count);
        bit [10:0] sets [8];
        bit [63:0] pcs [4];
        bit [63:0] base;
        bit [63:0] step;
        bit [15:0] mask;
        bit [10:0] s;
        int        run;
        int        done;
        int        i;
        foreach (sets[k])
            sets[k] = 11'((k < 2) ? k : (k < 4 ? 64 + k - 2 : $urandom_range(0, 2047)));
        foreach (pcs[k]) pcs[k] = rand64();
        done = 0;
        while (done < count) begin
            if ($urandom_range(0, 9) < 7) begin
                s = sets[$urandom_range(0, 7)];
                base = rand64();
                step = ($urandom_range(0, 3) == 0) ? rand64() : 64'(64 * $urandom_range(1, 8));
                run = $urandom_range(3, 10);
                for (i = 0; i < run; i++) begin
                    if ($urandom_range(0, 2) == 0) begin
                        mask = ($urandom_range(0, 1)) ? 16'hFFFF & ~(16'h1 << $urandom_range(0, 15))
                                                       : 16'($urandom());
                        send_fields(1'b0, s, 4'($urandom()), mask, rand64(), rand64(), 1'($urandom()));
                        done++;
                    end
                    send_fields(1'b1, s, 4'($urandom()), 16'($urandom()), pcs[$urandom_range(0, 3)],
                                base + step * 64'(i), $urandom_range(0, 3) == 0);
                    done++;
                end
            end else begin
                send_fields(1'($urandom()), 11'($urandom()), 4'($urandom()), 16'($urandom()),
                            rand64(), rand64(), 1'($urandom()));
                done++;
            end
        end
    endtask

    // Result side: random pops, one long hold-off on request
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    pop <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                pop <= 1'b1;
                @(posedge i_clk);
                if (!empty) tracker.check_victim(o_victim_way, o_victim_was_invalid);
            end
        end
    end

    // Stimulus
    initial begin
        int i;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: fresh sets, extremes of every field, leaders, hits and fills
        send_fields(1'b0, 11'd0, 4'd0, 16'h0000, '0, '0, 1'b0);
        send_fields(1'b0, 11'd2047, 4'd15, 16'hFFFF, '1, '1, 1'b1);
        send_fields(1'b1, 11'd5, 4'd15, 16'hFFFF, '1, '1, 1'b1);
        send_fields(1'b1, 11'd5, 4'd0, 16'h0000, '0, 64'h40, 1'b0);
        send_fields(1'b0, 11'd5, 4'd0, 16'hFFFF, '0, '0, 1'b0);
        send_fields(1'b1, 11'd0, 4'd3, 16'h0, 64'h1234, 64'h1000, 1'b0);
        send_fields(1'b1, 11'd1, 4'd3, 16'h0, 64'h1234, 64'h1000, 1'b1);
        send_fields(1'b1, 11'd2047, 4'd7, 16'h0, 64'h8000_0000_0000_0000, '1, 1'b0);
        send_fields(1'b0, 11'd1, 4'd0, 16'hFFFF, '0, '0, 1'b0);
        // constant stride makes the set streaming; then an invalid way is taken
        for (i = 0; i < 8; i++)
            send_fields(1'b1, 11'd3, 4'(i), 16'h0, 64'h77, 64'h10000 + 64'(64 * i), 1'b0);
        send_fields(1'b0, 11'd3, 4'd0, 16'hFFF7, '0, '0, 1'b0);
        send_fields(1'b0, 11'd3, 4'd0, 16'hFFFF, '0, '0, 1'b0);
        send_fields(1'b0, 11'd3, 4'd0, 16'h7FFF, '0, '0, 1'b0);
        // stride wrapping below zero
        send_fields(1'b1, 11'd9, 4'd1, 16'h0, '1, 64'h1, 1'b0);
        send_fields(1'b1, 11'd9, 4'd1, 16'h0, '1, 64'h0, 1'b0);

        // phase 1: reset settings, with a burst and a long receiver hold-off
        burst = 1'b1;
        random_phase(80);
        burst = 1'b0;
        hold_req = 1'b1;
        random_phase(140);

        // phase 2: lowest settings, bimodal period one
        configure(3'd0, 2'd0, 10'd0, 8'd1);
        random_phase(150);
        drain();  // sender waits for every victim
        random_phase(40);

        // phase 3: highest settings
        configure(3'd7, 2'd3, 10'd1023, 8'd255);
        random_phase(160);

        // phase 4: period zero and small nonzero values
        configure(3'd2, 2'd1, 10'd1, 8'd0);
        random_phase(120);

        // phase 5: random settings
        configure(3'($urandom()), 2'($urandom()), 10'($urandom()), 8'($urandom_range(1, 255)));
        random_phase(140);

        push <= 1'b0;
        while (tracker.pending_victims.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("Covered %0d items, %0d victims checked (%0d invalid-way picks in streaming sets)",
                 items_sent, tracker.victims_checked, tracker.stream_hits);
        $display("under five register settings including both extremes.");
        if (tracker.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
